>>> hdl/segment_coverage_counter_unit_defines.svh
// assertion macros used by the port level checker
`ifndef SEGMENT_COVERAGE_COUNTER_UNIT_DEFINES_SVH
`define SEGMENT_COVERAGE_COUNTER_UNIT_DEFINES_SVH

// implication checked at every edge, reset included
`define SCC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// implication checked outside reset
`define SCC_ASSERT_RUN(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/scc_pkg.sv
// shared constants and types for the segment coverage counter
`timescale 1ns / 1ps
package scc_pkg;

  localparam int HALF_RANGE   = 1024;
  localparam int SPAN         = 2 * HALF_RANGE;
  localparam int COORD_W      = 11;
  localparam int ADDR_W       = $clog2(SPAN);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int DIFF_W       = 17;
  localparam int COV_W        = 16;
  localparam int SEG_W        = 16;
  localparam int MAX_SEGMENTS = 65535;

  // request function codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ADD_L = 7'b0000100,
    S_ADD_R = 7'b0001000,
    S_REB   = 7'b0010000,
    S_QRD   = 7'b0100000,
    S_QDATA = 7'b1000000
  } state_t;

  // shared adder operations
  typedef enum logic [1:0] {
    OP_INC,
    OP_DEC,
    OP_ACC
  } alu_op_t;

endpackage

>>> hdl/scc_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface scc_in_if import scc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [COORD_W-1:0] left_end;
  logic signed [COORD_W-1:0] right_end;
  logic signed [COORD_W-1:0] point;

  modport source (output valid, func, left_end, right_end, point, input ready);
  modport sink   (input valid, func, left_end, right_end, point, output ready);
endinterface

interface scc_out_if import scc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COV_W-1:0] cover_count;

  modport source (output valid, cover_count, input ready);
  modport sink   (input valid, cover_count, output ready);
endinterface

>>> hdl/scc_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module scc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/scc_alu.sv
// shared adder for difference updates and the prefix sum walk
`timescale 1ns / 1ps
module scc_alu import scc_pkg::*; (
  input  alu_op_t                  op,
  input  logic signed [DIFF_W-1:0] diff_in,
  input  logic        [COV_W-1:0]  run_in,
  output logic        [DIFF_W-1:0] diff_out,
  output logic        [COV_W-1:0]  cov_out
);

  logic signed [DIFF_W:0] opnd_b;
  logic signed [DIFF_W:0] sum;

  // second operand select
  always_comb begin
    case (op)
      OP_INC:  opnd_b = (DIFF_W+1)'(1);
      OP_DEC:  opnd_b = -(DIFF_W+1)'(1);
      OP_ACC:  opnd_b = signed'((DIFF_W+1)'(run_in));
      default: opnd_b = '0;
    endcase
  end

  assign sum      = {diff_in[DIFF_W-1], diff_in} + opnd_b;
  assign diff_out = sum[DIFF_W-1:0];

  // clamp running coverage to the result width
  always_comb begin
    if (sum < 0) begin
      cov_out = '0;
    end else if (sum > signed'((DIFF_W+1)'({COV_W{1'b1}}))) begin
      cov_out = '1;
    end else begin
      cov_out = sum[COV_W-1:0];
    end
  end

endmodule

>>> hdl/segment_coverage_counter_unit.sv
// segment coverage counter top level: sequencer, stores and shared adder
// Usage:
//   in_ch carries requests: func add (left_end..right_end) or query (point).
//   out_ch returns one cover_count per query; adds give no result.
//   in_ch.ready is high only while the sequencer is idle.
// Sequence:
//   add: read/modify/write of both ends through one diff port in S_ADD_L and S_ADD_R;
//     S_ADD_R is skipped when the right end is the top coordinate; dropped adds do neither.
//   query on clean stores: read at accept, result registered from S_QDATA.
//   query after adds: a prefix sum walk over all 2048 entries rebuilds the
//     coverage store first, one entry per cycle through the shared adder,
//     then S_QRD reads it and S_QDATA registers the result.
// Reset:
//   rst_n is synchronous; a clearing pass over all 2048 entries zeroes both
//   stores, with in_ch.ready low until it ends.
// Stall:
//   a result waits in the output register; a later query holds in its
//   final read state until out_ch takes the pending result.
`timescale 1ns / 1ps
module segment_coverage_counter_unit import scc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  scc_in_if.sink   in_ch,
  scc_out_if.source out_ch
);

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [COV_W-1:0]  run_r;
  logic              dirty_r;
  logic [SEG_W-1:0]  total_r;
  logic [ADDR_W-1:0] lidx_r;
  logic [ADDR_W-1:0] ridx_r;
  logic              rtop_r;
  logic [ADDR_W-1:0] pidx_r;
  logic              out_valid_r;
  logic [COV_W-1:0]  out_count_r;

  logic              accept;
  logic [ADDR_W-1:0] lidx;
  logic [ADDR_W-1:0] ridx;
  logic [ADDR_W-1:0] pidx;
  logic [ADDR_W-1:0] rnext;
  logic              seg_ok;
  logic              rtop;

  logic              diff_we;
  logic [ADDR_W-1:0] diff_waddr;
  logic [DIFF_W-1:0] diff_wdata;
  logic              diff_re;
  logic [ADDR_W-1:0] diff_raddr;
  logic [DIFF_W-1:0] diff_rdata;

  logic              cov_we;
  logic [ADDR_W-1:0] cov_waddr;
  logic [COV_W-1:0]  cov_wdata;
  logic              cov_re;
  logic [ADDR_W-1:0] cov_raddr;
  logic [COV_W-1:0]  cov_rdata;

  alu_op_t           alu_op;
  logic [DIFF_W-1:0] alu_diff;
  logic [COV_W-1:0]  alu_cov;

  // request decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign lidx        = ADDR_W'(int'(in_ch.left_end) + HALF_RANGE);
  assign ridx        = ADDR_W'(int'(in_ch.right_end) + HALF_RANGE);
  assign pidx        = ADDR_W'(int'(in_ch.point) + HALF_RANGE);
  assign rtop        = (ridx == ADDR_W'(SPAN - 1));
  assign rnext       = ridx_r + 1'b1;
  assign seg_ok      = (in_ch.left_end <= in_ch.right_end) &&
                       (total_r < SEG_W'(MAX_SEGMENTS));

  // adder operation by state
  always_comb begin
    case (state_r)
      S_ADD_L: alu_op = OP_INC;
      S_ADD_R: alu_op = OP_DEC;
      default: alu_op = OP_ACC;
    endcase
  end

  // difference store ports
  always_comb begin
    diff_we    = 1'b0;
    diff_waddr = lidx_r;
    diff_wdata = alu_diff;
    diff_re    = 1'b0;
    diff_raddr = lidx;
    unique case (state_r)
      S_CLR: begin
        diff_we    = 1'b1;
        diff_waddr = cnt_r[ADDR_W-1:0];
        diff_wdata = '0;
      end
      S_IDLE: begin
        diff_re = accept && (in_ch.func == FUNC_ADD) && seg_ok;
      end
      S_ADD_L: begin
        diff_we    = 1'b1;
        diff_re    = !rtop_r;
        diff_raddr = rnext;
      end
      S_ADD_R: begin
        diff_we    = 1'b1;
        diff_waddr = rnext;
      end
      S_REB: begin
        diff_re    = (cnt_r < CNT_W'(SPAN));
        diff_raddr = cnt_r[ADDR_W-1:0];
      end
      S_QRD, S_QDATA: begin
        diff_re = 1'b0;
      end
      default: diff_re = 1'b0;
    endcase
  end

  // coverage store ports
  always_comb begin
    cov_we    = 1'b0;
    cov_waddr = ADDR_W'(cnt_r - 1'b1);
    cov_wdata = alu_cov;
    cov_re    = 1'b0;
    cov_raddr = pidx;
    unique case (state_r)
      S_CLR: begin
        cov_we    = 1'b1;
        cov_waddr = cnt_r[ADDR_W-1:0];
        cov_wdata = '0;
      end
      S_IDLE: begin
        cov_re = accept && (in_ch.func == FUNC_QUERY) && !dirty_r;
      end
      S_REB: begin
        cov_we = (cnt_r != '0);
      end
      S_QRD: begin
        cov_re    = 1'b1;
        cov_raddr = pidx_r;
      end
      S_ADD_L, S_ADD_R, S_QDATA: begin
        cov_re = 1'b0;
      end
      default: cov_re = 1'b0;
    endcase
  end

  scc_ram #(.WIDTH(DIFF_W), .DEPTH(SPAN)) u_diff_ram (
    .clk   (clk),
    .we    (diff_we),
    .waddr (diff_waddr),
    .wdata (diff_wdata),
    .re    (diff_re),
    .raddr (diff_raddr),
    .rdata (diff_rdata)
  );

  scc_ram #(.WIDTH(COV_W), .DEPTH(SPAN)) u_cov_ram (
    .clk   (clk),
    .we    (cov_we),
    .waddr (cov_waddr),
    .wdata (cov_wdata),
    .re    (cov_re),
    .raddr (cov_raddr),
    .rdata (cov_rdata)
  );

  scc_alu u_alu (
    .op       (alu_op),
    .diff_in  (signed'(diff_rdata)),
    .run_in   (run_r),
    .diff_out (alu_diff),
    .cov_out  (alu_cov)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      run_r   <= '0;
      dirty_r <= 1'b0;
      total_r <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          if (cnt_r == CNT_W'(SPAN - 1)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_ch.func == FUNC_ADD) begin
              if (seg_ok) begin
                state_r <= S_ADD_L;
              end
            end else if (dirty_r) begin
              cnt_r   <= '0;
              run_r   <= '0;
              state_r <= S_REB;
            end else begin
              state_r <= S_QDATA;
            end
          end
        end
        S_ADD_L: begin
          total_r <= total_r + 1'b1;
          dirty_r <= 1'b1;
          state_r <= rtop_r ? S_IDLE : S_ADD_R;
        end
        S_ADD_R: begin
          state_r <= S_IDLE;
        end
        S_REB: begin
          if (cnt_r != '0) begin
            run_r <= alu_cov;
          end
          if (cnt_r == CNT_W'(SPAN)) begin
            dirty_r <= 1'b0;
            state_r <= S_QRD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_QRD: begin
          state_r <= S_QDATA;
        end
        S_QDATA: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // captured request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      lidx_r <= lidx;
      ridx_r <= ridx;
      rtop_r <= rtop;
      pidx_r <= pidx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_QDATA) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_QDATA) && (!out_valid_r || out_ch.ready)) begin
      out_count_r <= cov_rdata;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cover_count = out_count_r;

endmodule

>>> hdl/scc_checker.sv
// port level checks for the segment coverage counter
`timescale 1ns / 1ps
`include "segment_coverage_counter_unit_defines.svh"
module scc_checker import scc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_func,
  input logic             out_valid,
  input logic             out_ready,
  input logic [COV_W-1:0] out_cover_count
);

  // reset starts the clearing pass, so no request is taken right after
  `SCC_ASSERT_ALWAYS(a_reset_busy, !rst_n, ##1 !in_ready, "ready high right after reset")

  // an accepted query takes the sequencer out of idle, so ready drops
  `SCC_ASSERT_RUN(a_query_busy, in_valid && in_ready && (in_func == FUNC_QUERY), ##1 !in_ready,
    "ready high the cycle after a query")

  // a stalled result stays offered
  `SCC_ASSERT_RUN(a_out_hold, out_valid && !out_ready, ##1 out_valid, "result dropped while stalled")

  // a stalled result keeps its value
  `SCC_ASSERT_RUN(a_out_stable, out_valid && !out_ready, ##1 $stable(out_cover_count),
    "result changed while stalled")

endmodule

bind segment_coverage_counter_unit scc_checker u_scc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_func         (in_ch.func),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_cover_count (out_ch.cover_count)
);

>>> verif/scc_coverage_check.sv
// checker for the segment coverage counter: predicts each cover_count and compares
`timescale 1ns / 1ps
module scc_coverage_check import scc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_func,
  input  logic signed [COORD_W-1:0] in_left_end,
  input  logic signed [COORD_W-1:0] in_right_end,
  input  logic signed [COORD_W-1:0] in_point,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [COV_W-1:0]          out_cover_count,
  output int                        mismatch_count,
  output int                        pending_results
);

  // own copy of the block state
  int               seg_diff [0:SPAN];
  logic [COV_W-1:0] seg_cover [0:SPAN-1];
  logic             cover_stale;
  int               seg_count;

  // cover counts owed by accepted queries, oldest first
  logic [COV_W-1:0] owed_counts [$];

  function automatic bit coord_ok(input int c);
    return c >= -HALF_RANGE && c <= HALF_RANGE - 1;
  endfunction

  task automatic clear_model();
    for (int i = 0; i <= SPAN; i++) seg_diff[i] = 0;
    for (int i = 0; i < SPAN; i++) seg_cover[i] = '0;
    cover_stale = 1'b0;
    seg_count = 0;
  endtask

  // +1 at the left end, -1 one past the right end
  task automatic note_segment(input logic signed [COORD_W-1:0] lo,
                              input logic signed [COORD_W-1:0] hi);
    int l;
    int r;
    l = lo;
    r = hi;
    if (l > r || !coord_ok(l) || !coord_ok(r)) return;
    if (seg_count >= MAX_SEGMENTS) return;
    seg_diff[HALF_RANGE + l] += 1;
    seg_diff[HALF_RANGE + r + 1] -= 1;
    seg_count++;
    cover_stale = 1'b1;
  endtask

  // prefix sum over the difference entries; the extra top entry is never read
  function automatic void rebuild_cover();
    longint run;
    run = 0;
    for (int i = 0; i < SPAN; i++) begin
      run += seg_diff[i];
      if (run < 0) seg_cover[i] = '0;
      else if (run > 65535) seg_cover[i] = 16'hFFFF;
      else seg_cover[i] = run[COV_W-1:0];
    end
    cover_stale = 1'b0;
  endfunction

  function automatic logic [COV_W-1:0] cover_at(input logic signed [COORD_W-1:0] pt);
    int x;
    x = pt;
    if (cover_stale) rebuild_cover();
    if (!coord_ok(x)) return '0;
    return seg_cover[HALF_RANGE + x];
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    logic [COV_W-1:0] want;
    if (!rst_n) begin
      clear_model();
      owed_counts.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_counts.size() == 0) begin
          $error("cover_count: no result expected, actual %0d", out_cover_count);
          mismatch_count++;
        end else begin
          want = owed_counts.pop_front();
          if (out_cover_count !== want) begin
            $error("cover_count: expected %0d, actual %0d", want, out_cover_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_ADD) note_segment(in_left_end, in_right_end);
        else owed_counts = {owed_counts, cover_at(in_point)};
      end
    end
    pending_results = owed_counts.size();
  end

endmodule

>>> verif/segment_coverage_counter_unit_tb.sv
// top of the segment coverage counter testbench: clock, reset, requests and verdict
`timescale 1ns / 1ps
module segment_coverage_counter_unit_tb;
  import scc_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 20000000;

  logic clk;
  logic rst_n;
  bit   calm;
  int   cycle_count = 0;
  int   counted_items;
  int   mismatches;
  int   pending;

  scc_in_if  in_ch ();
  scc_out_if out_ch ();

  segment_coverage_counter_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scc_coverage_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_func         (in_ch.func),
    .in_left_end     (in_ch.left_end),
    .in_right_end    (in_ch.right_end),
    .in_point        (in_ch.point),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_cover_count (out_ch.cover_count),
    .mismatch_count  (mismatches),
    .pending_results (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // gap length: mostly short, a few long, none in calm stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return -HALF_RANGE;
      1: return HALF_RANGE - 1;
      2: return -HALF_RANGE + $urandom_range(0, 3);
      3: return HALF_RANGE - 1 - $urandom_range(0, 3);
      default: return int'($urandom_range(0, SPAN - 1)) - HALF_RANGE;
    endcase
  endfunction

  function automatic int clip_coord(input int c);
    if (c > HALF_RANGE - 1) return HALF_RANGE - 1;
    if (c < -HALF_RANGE) return -HALF_RANGE;
    return c;
  endfunction

  // one request: optional gap, then hold until the handshake
  task automatic send_request(input logic fn, input int lo, input int hi, input int pt);
    int idle;
    idle = idle_len();
    if (idle > 0) begin
      in_ch.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.func      = fn;
    in_ch.left_end  = lo[COORD_W-1:0];
    in_ch.right_end = hi[COORD_W-1:0];
    in_ch.point     = pt[COORD_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (fn == FUNC_QUERY || lo <= hi) counted_items++;
  endtask

  task automatic add_seg(input int lo, input int hi);
    send_request(FUNC_ADD, lo, hi, rand_coord());
  endtask

  task automatic query_at(input int pt);
    send_request(FUNC_QUERY, rand_coord(), rand_coord(), pt);
  endtask

  // result side stalls
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int a;
    int b;
    int lo;
    int hi;
    int pt;
    int last_lo;
    int last_hi;
    rst_n           = 1'b0;
    calm            = 1'b0;
    counted_items   = 0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_ADD;
    in_ch.left_end  = '0;
    in_ch.right_end = '0;
    in_ch.point     = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty stores, extremes, top right end, reversed segments
    query_at(-HALF_RANGE);
    query_at(HALF_RANGE - 1);
    add_seg(-HALF_RANGE, HALF_RANGE - 1);
    add_seg(HALF_RANGE - 1, HALF_RANGE - 1);
    add_seg(-HALF_RANGE, -HALF_RANGE);
    add_seg(0, 0);
    add_seg(5, 3);
    add_seg(-1, 0);
    query_at(-HALF_RANGE);
    query_at(HALF_RANGE - 1);
    query_at(0);
    query_at(-1);
    query_at(5);
    // reversed add leaves the stores clean
    add_seg(HALF_RANGE - 1, -HALF_RANGE);
    query_at(HALF_RANGE - 1);
    add_seg(-5, HALF_RANGE - 2);
    query_at(HALF_RANGE - 1);
    query_at(HALF_RANGE - 2);
    query_at(-6);
    last_lo = 0;
    last_hi = 0;

    // random bursts: a run of adds, then a run of queries mostly near the last segment
    while (counted_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 14)) begin
        a = rand_coord();
        b = rand_coord();
        if ($urandom_range(0, 9) == 0) begin
          // reversed segment
          lo = (a > b) ? a : b;
          hi = (a > b) ? b : a;
        end else begin
          if ($urandom_range(0, 2) == 0) b = clip_coord(a + $urandom_range(0, 8));
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          last_lo = lo;
          last_hi = hi;
        end
        add_seg(lo, hi);
      end
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 4))
          0: pt = last_lo;
          1: pt = last_hi;
          2: pt = clip_coord(last_hi + 1);
          3: pt = clip_coord(last_lo - 1);
          default: pt = rand_coord();
        endcase
        query_at(pt);
      end
    end

    // closing mix of extreme segments and queries
    calm = 1'b0;
    query_at(0);
    add_seg(-HALF_RANGE, HALF_RANGE - 1);
    add_seg(0, 0);
    add_seg(HALF_RANGE - 1, HALF_RANGE - 1);
    query_at(-HALF_RANGE);
    query_at(0);
    query_at(HALF_RANGE - 1);
    query_at(rand_coord());
    add_seg(3, -3);
    query_at(rand_coord());
    in_ch.valid = 1'b0;

    // drain
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
